@@ design/lifo_pkg.sv @@
// Shared constants, codes and types of the LIFO stack with search.
package lifo_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = 5;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      FUNC_PUSH   = 3'd0,
      FUNC_POP    = 3'd1,
      FUNC_PEEK   = 3'd2,
      FUNC_SEARCH = 3'd3,
      FUNC_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_UNDER = 2'd1,
      STATUS_OVER  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

endpackage

@@ design/lifo_stack_with_search_top.sv @@
// LIFO stack of signed words with search, held in a one-port synchronous memory.
// Push, pop, peek, clear and unused codes: the accepted item starts a memory read, then the
// result and fill level are updated once the output is free; no new item is taken before the result is loaded.
// Search reads one entry per cycle from the bottom and stops at the first match
// or at the top entry, comparing at most 16 entries; on an empty stack no entry is compared.
// Reset clears the fill level and the output valid; the stored words are not cleared.
module lifo_stack_with_search_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // value[31:0]
   input  logic [2:0]  req_tuser,  // func[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // top_value[31:0], found[32], is_empty[33], entry_count[38:34], status[40:39], zeros
   output logic [47:0] rsp_tdata
);

   logic [lifo_pkg::DATA_W-1:0] mem [lifo_pkg::DEPTH];

   lifo_pkg::state_type state_ff, state_in;
   lifo_pkg::func_type  op_ff;
   logic signed [lifo_pkg::DATA_W-1:0] val_ff;
   logic [lifo_pkg::DATA_W-1:0] rd_data_ff;
   logic [lifo_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic [lifo_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic                        found_ff, found_in;

   logic                        rsp_valid_ff;
   logic signed [lifo_pkg::DATA_W-1:0] rsp_top_ff, top_in;
   logic                        rsp_found_ff;
   logic                        rsp_empty_ff;
   logic [lifo_pkg::CNT_W-1:0]  rsp_count_ff;
   lifo_pkg::status_type        rsp_status_ff, status_in;

   logic                        accept;
   logic                        load;
   logic                        rd_en;
   logic [lifo_pkg::ADDR_W-1:0] rd_addr;
   logic                        wr_en;
   logic                        scan_hit;
   logic                        scan_last;
   logic [lifo_pkg::CNT_W-1:0]  idx_next;

   assign accept    = req_tvalid && req_tready;
   assign idx_next  = lifo_pkg::CNT_W'(idx_ff) + lifo_pkg::CNT_W'(1);
   assign scan_hit  = (rd_data_ff == val_ff);
   assign scan_last = (idx_next >= fill_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lifo_pkg::S_IDLE: begin
            if (accept) begin
               if ((lifo_pkg::func_type'(req_tuser) == lifo_pkg::FUNC_SEARCH) &&
                   (fill_ff != '0)) begin
                  state_in = lifo_pkg::S_SCAN;
               end else begin
                  state_in = lifo_pkg::S_FINISH;
               end
            end
         end
         lifo_pkg::S_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = lifo_pkg::S_FINISH;
            end
         end
         lifo_pkg::S_FINISH: begin
            if (load) begin
               state_in = lifo_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lifo_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = (state_ff == lifo_pkg::S_IDLE);
      load       = (state_ff == lifo_pkg::S_FINISH) && (!rsp_valid_ff || rsp_tready);
      rd_en      = 1'b0;
      rd_addr    = '0;
      idx_in     = idx_ff;
      found_in   = found_ff;
      wr_en      = 1'b0;
      fill_in    = fill_ff;
      top_in     = '0;
      status_in  = lifo_pkg::STATUS_OK;
      case (state_ff)
         lifo_pkg::S_IDLE: begin
            if (accept) begin
               rd_en    = 1'b1;
               found_in = 1'b0;
               idx_in   = '0;
               if (lifo_pkg::func_type'(req_tuser) == lifo_pkg::FUNC_SEARCH) begin
                  rd_addr = '0;
               end else begin
                  rd_addr = lifo_pkg::ADDR_W'(fill_ff - lifo_pkg::CNT_W'(1));
               end
            end
         end
         lifo_pkg::S_SCAN: begin
            if (scan_hit) begin
               found_in = 1'b1;
            end else if (!scan_last) begin
               idx_in  = idx_next[lifo_pkg::ADDR_W-1:0];
               rd_en   = 1'b1;
               rd_addr = idx_next[lifo_pkg::ADDR_W-1:0];
            end
         end
         lifo_pkg::S_FINISH: begin
            case (op_ff)
               lifo_pkg::FUNC_PUSH: begin
                  if (fill_ff >= lifo_pkg::CNT_W'(lifo_pkg::DEPTH)) begin
                     status_in = lifo_pkg::STATUS_OVER;
                  end else begin
                     wr_en   = load;
                     fill_in = fill_ff + lifo_pkg::CNT_W'(1);
                  end
               end
               lifo_pkg::FUNC_POP: begin
                  if (fill_ff == '0) begin
                     status_in = lifo_pkg::STATUS_UNDER;
                  end else begin
                     fill_in = fill_ff - lifo_pkg::CNT_W'(1);
                  end
               end
               lifo_pkg::FUNC_PEEK: begin
                  if (fill_ff == '0) begin
                     top_in    = '1;
                     status_in = lifo_pkg::STATUS_UNDER;
                  end else begin
                     top_in = rd_data_ff;
                  end
               end
               lifo_pkg::FUNC_CLEAR: begin
                  fill_in = '0;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[fill_ff[lifo_pkg::ADDR_W-1:0]] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lifo_pkg::S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            fill_ff      <= fill_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      found_ff <= found_in;
      if (accept) begin
         op_ff  <= lifo_pkg::func_type'(req_tuser);
         val_ff <= req_tdata;
      end
      if (load) begin
         rsp_top_ff    <= top_in;
         rsp_found_ff  <= (op_ff == lifo_pkg::FUNC_SEARCH) && found_ff;
         rsp_empty_ff  <= (fill_in == '0);
         rsp_count_ff  <= fill_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_count_ff, rsp_empty_ff, rsp_found_ff,
                        rsp_top_ff};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= lifo_pkg::CNT_W'(lifo_pkg::DEPTH))
      else $error("fill level exceeds the stack depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (fill_ff < lifo_pkg::CNT_W'(lifo_pkg::DEPTH)) && load)
      else $error("memory write without room or without a result");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != lifo_pkg::S_IDLE))
      else $error("accepted item did not start work");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == fill_ff) && (rsp_empty_ff == (fill_ff == '0)))
      else $error("held result count disagrees with fill level");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

@@ bench/tb.sv @@
// Self-checking testbench of the LIFO stack: a directed table of items, then random items.
module tb;

   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [2:0]  FUNC_SPARE_5  = 3'd5;
   localparam logic [2:0]  FUNC_SPARE_6  = 3'd6;
   localparam logic [2:0]  FUNC_SPARE_7  = 3'd7;
   localparam logic [31:0] WORD_MIN      = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX      = 32'h7FFF_FFFF;
   localparam logic [31:0] WORD_ALL_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      lifo_pkg::status_type status;
      logic [4:0]  entry_count;
      logic        is_empty;
      logic        found;
      logic [31:0] top_value;
   } stack_result_type;

   typedef struct {
      logic [2:0]       func;
      logic [31:0]      value;
      int               reps;
      bit               typed;
      stack_result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // value[31:0]
   logic [2:0]  req_tuser = '0;  // func[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // top_value[31:0], found[32], is_empty[33], entry_count[38:34], status[40:39], zeros
   logic [47:0] rsp_tdata;

   logic [31:0]      stack_words [lifo_pkg::DEPTH];
   int               stack_level = 0;
   stack_result_type pending_results [$];
   stim_row_type     stim_table [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               burst_left = 0;

   lifo_stack_with_search_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic stack_result_type make_result(logic [31:0] top, logic hit, logic empty,
                                                    logic [4:0] count,
                                                    lifo_pkg::status_type st);
      stack_result_type r;
      r.top_value   = top;
      r.found       = hit;
      r.is_empty    = empty;
      r.entry_count = count;
      r.status      = st;
      return r;
   endfunction

   function automatic stack_result_type predict_stack(logic [2:0] func, logic [31:0] value);
      stack_result_type r;
      r = make_result(32'd0, 1'b0, 1'b0, 5'd0, lifo_pkg::STATUS_OK);
      case (func)
         lifo_pkg::FUNC_PUSH: begin
            if (stack_level >= lifo_pkg::DEPTH) begin
               r.status = lifo_pkg::STATUS_OVER;
            end else begin
               stack_words[stack_level] = value;
               stack_level++;
            end
         end
         lifo_pkg::FUNC_POP: begin
            if (stack_level == 0) r.status = lifo_pkg::STATUS_UNDER;
            else stack_level--;
         end
         lifo_pkg::FUNC_PEEK: begin
            if (stack_level == 0) begin
               r.top_value = WORD_ALL_ONES;
               r.status    = lifo_pkg::STATUS_UNDER;
            end else begin
               r.top_value = stack_words[stack_level - 1];
            end
         end
         lifo_pkg::FUNC_SEARCH: begin
            for (int i = 0; i < stack_level; i++)
               if (stack_words[i] == value) r.found = 1'b1;
         end
         lifo_pkg::FUNC_CLEAR: begin
            stack_level = 0;
         end
         default: begin
         end
      endcase
      r.is_empty    = (stack_level == 0);
      r.entry_count = stack_level[4:0];
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return WORD_ALL_ONES;
         3: return 32'd0;
         4, 5: return 32'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   task automatic add_row(logic [2:0] func, logic [31:0] value, int reps, bit typed,
                          stack_result_type want);
      stim_row_type row;
      row.func  = func;
      row.value = value;
      row.reps  = reps;
      row.typed = typed;
      row.want  = want;
      stim_table.push_back(row);
   endtask

   task automatic send_item(logic [2:0] func, logic [31:0] value, bit typed,
                            stack_result_type want);
      stack_result_type predicted;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predicted = predict_stack(func, value);
      pending_results.push_back(typed ? want : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 24);
      end
   endtask

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      stack_result_type got;
      stack_result_type want;
      cycle_count <= cycle_count + 1;
      case (cycle_count[8:7])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= (cycle_count[1:0] == 2'd0);
         2'd2: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 9) != 0);
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = stack_result_type'(rsp_tdata[40:0]);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            report_field("top_value", want.top_value, got.top_value);
            report_field("found", 32'(want.found), 32'(got.found));
            report_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            report_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
            report_field("status", 32'(want.status), 32'(got.status));
         end
      end
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("** lifo_stack_with_search_top: FAILED **");
      $finish;
   end

   initial begin
      stack_result_type none;
      int push_share;
      int pick;
      logic [2:0] func;
      logic [31:0] value;

      none = make_result(32'd0, 1'b0, 1'b0, 5'd0, lifo_pkg::STATUS_OK);
      add_row(lifo_pkg::FUNC_POP, 32'd0, 1, 1'b1,
              make_result(32'd0, 1'b0, 1'b1, 5'd0, lifo_pkg::STATUS_UNDER));
      add_row(lifo_pkg::FUNC_PEEK, 32'd0, 1, 1'b1,
              make_result(WORD_ALL_ONES, 1'b0, 1'b1, 5'd0, lifo_pkg::STATUS_UNDER));
      add_row(lifo_pkg::FUNC_SEARCH, 32'd0, 1, 1'b1,
              make_result(32'd0, 1'b0, 1'b1, 5'd0, lifo_pkg::STATUS_OK));
      add_row(FUNC_SPARE_5, WORD_ALL_ONES, 1, 1'b1,
              make_result(32'd0, 1'b0, 1'b1, 5'd0, lifo_pkg::STATUS_OK));
      add_row(lifo_pkg::FUNC_PUSH, WORD_MIN, 1, 1'b1,
              make_result(32'd0, 1'b0, 1'b0, 5'd1, lifo_pkg::STATUS_OK));
      add_row(lifo_pkg::FUNC_PEEK, 32'd0, 1, 1'b1,
              make_result(WORD_MIN, 1'b0, 1'b0, 5'd1, lifo_pkg::STATUS_OK));
      add_row(lifo_pkg::FUNC_PUSH, WORD_MAX, 1, 1'b1,
              make_result(32'd0, 1'b0, 1'b0, 5'd2, lifo_pkg::STATUS_OK));
      add_row(lifo_pkg::FUNC_SEARCH, WORD_MIN, 1, 1'b1,
              make_result(32'd0, 1'b1, 1'b0, 5'd2, lifo_pkg::STATUS_OK));
      add_row(lifo_pkg::FUNC_SEARCH, WORD_ALL_ONES, 1, 1'b1,
              make_result(32'd0, 1'b0, 1'b0, 5'd2, lifo_pkg::STATUS_OK));
      add_row(lifo_pkg::FUNC_PUSH, WORD_ALL_ONES, lifo_pkg::DEPTH - 2, 1'b0, none);
      add_row(lifo_pkg::FUNC_PUSH, 32'd0, 1, 1'b1,
              make_result(32'd0, 1'b0, 1'b0, 5'd16, lifo_pkg::STATUS_OVER));
      add_row(lifo_pkg::FUNC_SEARCH, WORD_MAX, 1, 1'b0, none);
      add_row(lifo_pkg::FUNC_SEARCH, 32'd0, 1, 1'b0, none);
      add_row(lifo_pkg::FUNC_PEEK, 32'd0, 1, 1'b0, none);
      add_row(FUNC_SPARE_6, WORD_MAX, 1, 1'b0, none);
      add_row(FUNC_SPARE_7, WORD_MIN, 1, 1'b0, none);
      add_row(lifo_pkg::FUNC_POP, 32'd0, 1, 1'b0, none);
      add_row(lifo_pkg::FUNC_PEEK, 32'd0, 1, 1'b0, none);
      add_row(lifo_pkg::FUNC_CLEAR, WORD_ALL_ONES, 1, 1'b1,
              make_result(32'd0, 1'b0, 1'b1, 5'd0, lifo_pkg::STATUS_OK));
      add_row(lifo_pkg::FUNC_POP, 32'd0, 1, 1'b1,
              make_result(32'd0, 1'b0, 1'b1, 5'd0, lifo_pkg::STATUS_UNDER));
      add_row(lifo_pkg::FUNC_PEEK, 32'd0, 1, 1'b1,
              make_result(WORD_ALL_ONES, 1'b0, 1'b1, 5'd0, lifo_pkg::STATUS_UNDER));
      add_row(lifo_pkg::FUNC_SEARCH, WORD_MAX, 1, 1'b1,
              make_result(32'd0, 1'b0, 1'b1, 5'd0, lifo_pkg::STATUS_OK));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[r])
         for (int k = 0; k < stim_table[r].reps; k++)
            send_item(stim_table[r].func, stim_table[r].value - 32'(k), stim_table[r].typed,
                      stim_table[r].want);

      push_share = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) push_share = $urandom_range(25, 75);
         pick  = $urandom_range(0, 99);
         value = pick_word();
         if (pick < 2) begin
            func = lifo_pkg::FUNC_CLEAR;
         end else if (pick < 5) begin
            func = 3'($urandom_range(5, 7));
         end else if (pick < 20) begin
            func = lifo_pkg::FUNC_SEARCH;
            if (stack_level > 0 && $urandom_range(0, 1) == 1)
               value = stack_words[$urandom_range(0, stack_level - 1)];
         end else if (pick < 30) begin
            func = lifo_pkg::FUNC_PEEK;
         end else if ($urandom_range(0, 99) < push_share) begin
            func = lifo_pkg::FUNC_PUSH;
         end else begin
            func = lifo_pkg::FUNC_POP;
         end
         send_item(func, value, 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** lifo_stack_with_search_top: PASSED **");
      end else begin
         $display("** lifo_stack_with_search_top: FAILED **");
      end
      $finish;
   end

endmodule
